FILE: design/vrc_bank_mapper_irq_top_defines.svh
// assertion helpers for the bank mapper
`ifndef VRC_BANK_MAPPER_IRQ_TOP_DEFINES_SVH
`define VRC_BANK_MAPPER_IRQ_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define VRCBM_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define VRCBM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vrcbm_pkg.sv
package vrcbm_pkg;

	// configuration register indexes
	localparam logic CFG_VARIANT  = 1'b0;
	localparam logic CFG_END_BANK = 1'b1;

	// item kinds
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// mapping spaces
	localparam logic [1:0] SPACE_PRG    = 2'd0;
	localparam logic [1:0] SPACE_CHR    = 2'd1;
	localparam logic [1:0] SPACE_MIRROR = 2'd2;

	// result queue depth default
	localparam int RES_DEPTH = 4;

	// one result word
	typedef struct packed {
		logic       irq;
		logic       map_valid;
		logic [1:0] map_space;
		logic [2:0] map_window;
		logic [8:0] map_bank;
		logic       last;
	} res_t;

endpackage

FILE: design/vrcbm_core.sv
module vrcbm_core
	import vrcbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        op,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	input  logic [3:0]  variant,
	input  logic [7:0]  end_bank,
	output res_t        res0,
	output res_t        res1,
	output logic        two
);

	// variant codes
	localparam logic [3:0] VAR_VRC2A = 4'd0;
	localparam logic [3:0] VAR_VRC2B = 4'd1;
	localparam logic [3:0] VAR_VRC2C = 4'd2;
	localparam logic [3:0] VAR_VRC4A = 4'd3;
	localparam logic [3:0] VAR_VRC4B = 4'd4;
	localparam logic [3:0] VAR_VRC4C = 4'd5;
	localparam logic [3:0] VAR_VRC4D = 4'd6;
	localparam logic [3:0] VAR_VRC4E = 4'd7;
	localparam logic [3:0] VAR_VRC4F = 4'd8;
	localparam logic [3:0] VAR_BRD23 = 4'd10;
	localparam logic [3:0] VAR_BRD25 = 4'd11;

	// register groups by address nibble
	localparam logic [3:0] REG_PRG    = 4'h8;
	localparam logic [3:0] REG_MODE   = 4'h9;
	localparam logic [3:0] REG_MID    = 4'hA;
	localparam logic [3:0] REG_CHR_B  = 4'hB;
	localparam logic [3:0] REG_CHR_C  = 4'hC;
	localparam logic [3:0] REG_CHR_D  = 4'hD;
	localparam logic [3:0] REG_CHR_E  = 4'hE;
	localparam logic [3:0] REG_IRQ    = 4'hF;

	// irq register selects
	localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
	localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
	localparam logic [1:0] IRQ_CTRL     = 2'd2;
	localparam logic [1:0] IRQ_ACK      = 2'd3;

	localparam logic [9:0] PRESC_RELOAD = 10'd341;
	localparam logic [9:0] PRESC_STEP   = 10'd3;

	function automatic logic [1:0] pin_exact(input logic [7:0] a, input logic [7:0] p0,
		input logic [7:0] p1, input logic [7:0] p2);
		if ((a & p0) == p0) return 2'd3;
		if ((a & p1) == p1) return 2'd2;
		if ((a & p2) == p2) return 2'd1;
		return 2'd0;
	endfunction

	function automatic logic [1:0] pin_loose(input logic [7:0] a, input logic [7:0] p0a,
		input logic [7:0] p0b, input logic [7:0] p1, input logic [7:0] p2);
		if ((a & p0a) == p0a || (a & p0b) == p0b) return 2'd3;
		if ((a & p1) != 8'h00) return 2'd2;
		if ((a & p2) != 8'h00) return 2'd1;
		return 2'd0;
	endfunction

	// board-specific address line routing
	function automatic logic [1:0] repin(input logic [3:0] v, input logic [7:0] a);
		case (v)
			VAR_VRC2A, VAR_VRC2C, VAR_VRC4B: return pin_exact(a, 8'h03, 8'h01, 8'h02);
			VAR_VRC2B, VAR_VRC4F:            return pin_exact(a, 8'h03, 8'h02, 8'h01);
			VAR_VRC4A:                       return pin_exact(a, 8'h06, 8'h04, 8'h02);
			VAR_VRC4C:                       return pin_exact(a, 8'hC0, 8'h80, 8'h40);
			VAR_VRC4D:                       return pin_exact(a, 8'h0C, 8'h04, 8'h08);
			VAR_VRC4E:                       return pin_exact(a, 8'h0C, 8'h08, 8'h04);
			VAR_BRD23:                       return pin_loose(a, 8'h0C, 8'h03, 8'h0A, 8'h05);
			VAR_BRD25:                       return pin_loose(a, 8'h0C, 8'h03, 8'h05, 8'h0A);
			default:                         return pin_loose(a, 8'h06, 8'hC0, 8'h84, 8'h42);
		endcase
	endfunction

	logic [4:0] prg_bank_q, prg_bank_d;
	logic       prg_swap_q, prg_swap_d;
	logic [8:0] chr_q [8];
	logic [7:0] latch_q, latch_d;
	logic [7:0] count_q, count_d;
	logic [9:0] presc_q, presc_d;
	logic       en_q, en_d;
	logic       rearm_q, rearm_d;
	logic       cyc_q, cyc_d;
	logic       ack_q, ack_d;
	logic       line_q, line_d;

	logic       chr_we;
	logic [2:0] chr_slot;
	logic [8:0] chr_val;
	logic [8:0] chr_old;

	logic       vrc2;
	logic [3:0] hi;
	logic [1:0] lo;
	logic [3:0] hi_off;
	logic [8:0] fixed_bank;
	logic       presc_le0;
	logic       tick_clk;
	logic       prg_update;

	assign vrc2       = (variant <= VAR_VRC2C);
	assign hi         = addr[15:12];
	assign hi_off     = hi - REG_CHR_B;
	assign chr_slot   = {hi_off[1:0], lo[1]};
	assign chr_old    = chr_q[chr_slot];
	assign fixed_bank = {1'b0, end_bank - 8'd1};
	assign presc_le0  = presc_q[9] || (presc_q == 10'd0);

	// address decode after re-pinning
	always_comb begin
		lo = repin(variant, addr[7:0]);
		if (hi == REG_MODE && lo >= 2'd2 && vrc2) begin
			lo = 2'd0;
		end
	end

	// next state and result words
	always_comb begin
		prg_bank_d = prg_bank_q;
		prg_swap_d = prg_swap_q;
		latch_d    = latch_q;
		count_d    = count_q;
		presc_d    = presc_q;
		en_d       = en_q;
		rearm_d    = rearm_q;
		cyc_d      = cyc_q;
		ack_d      = ack_q;
		line_d     = line_q;
		chr_we     = 1'b0;
		chr_val    = chr_old;
		prg_update = 1'b0;
		tick_clk   = 1'b0;
		res0       = '0;
		res1       = '0;
		if (op == OP_TICK) begin
			if (!vrc2) begin
				if (ack_q) begin
					line_d = 1'b0;
					ack_d  = 1'b0;
				end
				tick_clk = cyc_q || presc_le0;
				presc_d  = presc_le0 ? presc_q + PRESC_RELOAD - PRESC_STEP
					: presc_q - PRESC_STEP;
				if (en_q && tick_clk) begin
					if (count_q == 8'hFF) begin
						line_d  = 1'b1;
						count_d = latch_q;
					end else begin
						count_d = count_q + 8'd1;
					end
				end
			end
		end else if (addr[15]) begin
			case (hi)
				REG_PRG: begin
					prg_bank_d = data[4:0];
					prg_update = 1'b1;
				end
				REG_MODE: begin
					if (lo < 2'd2) begin
						res0.map_valid = 1'b1;
						res0.map_space = SPACE_MIRROR;
						res0.map_bank  = {7'd0, data[1] & !vrc2, data[0]};
					end else begin
						prg_swap_d = data[1];
						prg_update = 1'b1;
					end
				end
				REG_MID: begin
					res0.map_valid  = 1'b1;
					res0.map_space  = SPACE_PRG;
					res0.map_window = 3'd1;
					res0.map_bank   = {4'd0, data[4:0]};
				end
				REG_CHR_B, REG_CHR_C, REG_CHR_D, REG_CHR_E: begin
					chr_we = 1'b1;
					if (!lo[0]) begin
						chr_val = {chr_old[8:4], data[3:0]};
					end else begin
						chr_val = {data[4:0], chr_old[3:0]};
					end
					res0.map_valid  = 1'b1;
					res0.map_space  = SPACE_CHR;
					res0.map_window = chr_slot;
					res0.map_bank   = (variant == VAR_VRC2A) ? {1'b0, chr_val[8:1]} : chr_val;
				end
				REG_IRQ: begin
					case (lo)
						IRQ_LATCH_LO: latch_d = {latch_q[7:4], data[3:0]};
						IRQ_LATCH_HI: latch_d = {data[3:0], latch_q[3:0]};
						IRQ_CTRL: begin
							rearm_d = data[0];
							en_d    = data[1];
							cyc_d   = data[2];
							ack_d   = 1'b1;
							if (data[1]) begin
								count_d = latch_q;
								presc_d = PRESC_RELOAD;
							end
						end
						IRQ_ACK: begin
							ack_d = 1'b1;
							en_d  = rearm_q;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// prg window pair
		if (prg_update) begin
			res0.map_valid  = 1'b1;
			res0.map_space  = SPACE_PRG;
			res0.map_window = 3'd0;
			res0.map_bank   = prg_swap_d ? fixed_bank : {4'd0, prg_bank_d};
			res1.map_valid  = 1'b1;
			res1.map_space  = SPACE_PRG;
			res1.map_window = 3'd2;
			res1.map_bank   = prg_swap_d ? {4'd0, prg_bank_d} : fixed_bank;
		end
		res0.irq  = line_d;
		res1.irq  = line_d;
		res0.last = !prg_update;
		res1.last = 1'b1;
	end

	assign two = prg_update;

	// mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_q <= '0;
			prg_swap_q <= 1'b0;
			latch_q    <= '0;
			count_q    <= '0;
			presc_q    <= PRESC_RELOAD;
			en_q       <= 1'b0;
			rearm_q    <= 1'b0;
			cyc_q      <= 1'b0;
			ack_q      <= 1'b0;
			line_q     <= 1'b0;
		end else if (fire) begin
			prg_bank_q <= prg_bank_d;
			prg_swap_q <= prg_swap_d;
			latch_q    <= latch_d;
			count_q    <= count_d;
			presc_q    <= presc_d;
			en_q       <= en_d;
			rearm_q    <= rearm_d;
			cyc_q      <= cyc_d;
			ack_q      <= ack_d;
			line_q     <= line_d;
		end
	end

	// chr bank registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chr_q[i] <= '0;
			end
		end else if (fire && chr_we) begin
			chr_q[chr_slot] <= chr_val;
		end
	end

endmodule

FILE: design/vrcbm_res_fifo.sv
module vrcbm_res_fifo
	import vrcbm_pkg::*;
#(
	parameter int DEPTH = RES_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       two,
	input  res_t                       res0,
	input  res_t                       res1,
	input  logic                       pop,
	output res_t                       head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	res_t          mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_next;
	logic [CW-1:0] add;

	assign wr_next = ptr_inc(wr_ptr_q);
	assign add     = push ? (two ? CW'(2) : CW'(1)) : CW'(0);
	assign head    = mem[rd_ptr_q];
	assign count   = count_q;

	// result storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= res0;
			if (two) begin
				mem[wr_next] <= res1;
			end
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= two ? ptr_inc(wr_next) : wr_next;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + add - (pop ? CW'(1) : CW'(0));
		end
	end

endmodule

FILE: design/vrc_bank_mapper_irq_top.sv
// Bank mapper with scanline IRQ. Takes one word per clock while in_ready is high: a register
// write (op 0) or one CPU cycle tick (op 1). A word waits in the input register until the result
// queue has room, then its mapper update is done in a single pass and its results are written
// into a small result queue, whose head is offered on the output port. Writes to the PRG bank or
// PRG mode register give two results (window 0, then window 2); every other word gives one, marked
// by last. The output port hands out one result per cycle while out_ready is high, so sustained
// rate is one word per cycle while words give one result each; each two-result word puts a second
// result on the output. The queue depth (FIFO_DEPTH) sets how much output stall is absorbed before
// in_ready drops. Configuration writes must be made only while idle.
`include "vrc_bank_mapper_irq_top_defines.svh"

module vrc_bank_mapper_irq_top
	import vrcbm_pkg::*;
#(
	parameter int FIFO_DEPTH = RES_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        irq,
	output logic        map_valid,
	output logic [1:0]  map_space,
	output logic [2:0]  map_window,
	output logic [8:0]  map_bank,
	output logic        last
);

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [3:0]    variant_q;
	logic [7:0]    end_bank_q;
	logic          v_s1;
	logic          op_s1;
	logic [15:0]   addr_s1;
	logic [7:0]    data_s1;
	logic          fire;
	logic          room;
	logic          pop;
	logic          two;
	res_t          res0;
	res_t          res1;
	res_t          head;
	logic [CW-1:0] fill;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q  <= 4'd0;
			end_bank_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_VARIANT:  variant_q  <= cfg_wdata[3:0];
				CFG_END_BANK: end_bank_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	assign room     = (fill <= CW'(FIFO_DEPTH - 2));
	assign fire     = v_s1 && room;
	assign in_ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			addr_s1 <= addr;
			data_s1 <= data;
		end
	end

	vrcbm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.addr      (addr_s1),
		.data      (data_s1),
		.variant   (variant_q),
		.end_bank  (end_bank_q),
		.res0      (res0),
		.res1      (res1),
		.two       (two)
	);

	vrcbm_res_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.two    (two),
		.res0   (res0),
		.res1   (res1),
		.pop    (pop),
		.head   (head),
		.count  (fill)
	);

	// output port
	assign out_valid  = (fill != '0);
	assign pop        = out_valid && out_ready;
	assign irq        = head.irq;
	assign map_valid  = head.map_valid;
	assign map_space  = head.map_space;
	assign map_window = head.map_window;
	assign map_bank   = head.map_bank;
	assign last       = head.last;

	// checks
	`VRCBM_ASSERT_NOW(a_no_overflow, clk, arst_n, 1'b1, fill <= CW'(FIFO_DEPTH), "result queue overflow")
	`VRCBM_ASSERT_NEXT(a_stall_holds, clk, arst_n, v_s1 && !fire, v_s1 && $stable(addr_s1) && $stable(op_s1), "held word lost")
	`VRCBM_ASSERT_NEXT(a_drain, clk, arst_n, pop && fill == CW'(1) && !fire, !out_valid, "result invented")

endmodule
